FILE: sv/hlm_pkg.sv
// Shared types, constants and register map of the heartbeat link monitor.
package hlm_pkg;

  localparam int unsigned TIME_W   = 64;
  localparam int unsigned MAGIC_W  = 32;
  localparam int unsigned LEN_W    = 6;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned RTT_W    = 14;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned IN_DW    = 104;
  localparam int unsigned OUT_DW   = 80;

  localparam logic [MAGIC_W-1:0] MAGIC_PING  = 32'h5049_4E47;
  localparam logic [MAGIC_W-1:0] MAGIC_PONG  = 32'h504F_4E47;
  localparam logic [MAGIC_W-1:0] MAGIC_STOP  = 32'h5354_4F50;
  localparam logic [MAGIC_W-1:0] MAGIC_START = 32'h5354_5254;

  localparam logic [LEN_W-1:0] PROBE_BYTES = 6'd12;
  localparam logic [LEN_W-1:0] MIN_BYTES   = 6'd4;

  localparam logic [PERIOD_W-1:0] PING_PERIOD_RESET = 16'd1000;
  localparam logic [PERIOD_W-1:0] TIMEOUT_RESET     = 16'd3000;
  localparam logic [LIMIT_W-1:0]  RTT_LIMIT_RESET   = 13'd5000;

  localparam logic signed [RTT_W-1:0] RTT_NONE = -14'sd1;

  typedef enum logic [1:0] {
    SEND_NONE = 2'd0,
    SEND_PING = 2'd1,
    SEND_PONG = 2'd2
  } send_t;

  typedef enum logic [1:0] {
    REG_PING_PERIOD = 2'd0,
    REG_TIMEOUT     = 2'd1,
    REG_RTT_LIMIT   = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] ping_period;
    logic [PERIOD_W-1:0] timeout;
    logic [LIMIT_W-1:0]  rtt_limit;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [MAGIC_W-1:0] magic;
    logic [LEN_W-1:0]   length;
    logic [TIME_W-1:0]  stamp;
  } item_t;

  typedef struct packed {
    send_t                    send;
    logic [TIME_W-1:0]        send_stamp;
    logic                     connected;
    logic signed [RTT_W-1:0]  round_trip;
    logic                     paused;
  } result_t;

endpackage

FILE: sv/hlm_regs.sv
// Configuration registers of the heartbeat link monitor behind the APB port.
module hlm_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [hlm_pkg::APB_AW-1:0]   paddr,
  input  logic [hlm_pkg::APB_DW-1:0]   pwdata,
  output logic [hlm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output hlm_pkg::cfg_t                cfg
);
  import hlm_pkg::*;

  reg_index_t index;
  logic       write_en;

  assign pready   = 1'b1;
  assign index    = reg_index_t'(paddr[APB_AW-1:2]);
  assign write_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ping_period <= PING_PERIOD_RESET;
      cfg.timeout     <= TIMEOUT_RESET;
      cfg.rtt_limit   <= RTT_LIMIT_RESET;
    end else if (write_en) begin
      unique case (index)
        REG_PING_PERIOD: cfg.ping_period <= pwdata[PERIOD_W-1:0];
        REG_TIMEOUT:     cfg.timeout     <= pwdata[PERIOD_W-1:0];
        REG_RTT_LIMIT:   cfg.rtt_limit   <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_PING_PERIOD: prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg.ping_period};
      REG_TIMEOUT:     prdata = {{(APB_DW-PERIOD_W){1'b0}}, cfg.timeout};
      REG_RTT_LIMIT:   prdata = {{(APB_DW-LIMIT_W){1'b0}}, cfg.rtt_limit};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: sv/hlm_core.sv
// Link state and the update applied to each request.
module hlm_core (
  input  logic             clk,
  input  logic             rst,
  input  hlm_pkg::cfg_t    cfg,
  input  logic             step,
  input  hlm_pkg::item_t   item,
  output hlm_pkg::result_t result
);
  import hlm_pkg::*;

  logic [TIME_W-1:0]       clock_ms;
  logic [TIME_W-1:0]       clock_ms_next;
  logic [TIME_W-1:0]       last_heard;
  logic [TIME_W-1:0]       last_heard_next;
  logic [TIME_W-1:0]       last_ping_sent;
  logic [TIME_W-1:0]       last_ping_sent_next;
  logic                    link_up;
  logic                    link_up_next;
  logic signed [RTT_W-1:0] rtt_value;
  logic signed [RTT_W-1:0] rtt_value_next;
  logic                    pause_flag;
  logic                    pause_flag_next;

  logic [TIME_W-1:0] clock_inc;
  logic [TIME_W-1:0] rtt_diff;
  logic [TIME_W-1:0] silence;
  logic              ping_due;
  logic              rtt_ok;
  logic              long_enough;
  logic              probe_len;
  send_t             send;
  logic [TIME_W-1:0] send_stamp;

  assign clock_inc   = clock_ms + 1'b1;
  assign ping_due    = (clock_inc - last_ping_sent) >= {{(TIME_W-PERIOD_W){1'b0}}, cfg.ping_period};
  assign rtt_diff    = clock_ms - item.stamp;
  assign rtt_ok      = rtt_diff < {{(TIME_W-LIMIT_W){1'b0}}, cfg.rtt_limit};
  assign long_enough = item.length >= MIN_BYTES;
  assign probe_len   = item.length == PROBE_BYTES;

  always_comb begin
    clock_ms_next       = clock_ms;
    last_heard_next     = last_heard;
    last_ping_sent_next = last_ping_sent;
    link_up_next        = link_up;
    rtt_value_next      = rtt_value;
    pause_flag_next     = pause_flag;
    send                = SEND_NONE;
    send_stamp          = '0;
    if (!item.kind) begin
      clock_ms_next = clock_inc;
      if (ping_due) begin
        send                = SEND_PING;
        send_stamp          = clock_inc;
        last_ping_sent_next = clock_inc;
      end
    end else if (long_enough) begin
      if (item.magic == MAGIC_PING && probe_len) begin
        last_heard_next = clock_ms;
        link_up_next    = 1'b1;
        send            = SEND_PONG;
        send_stamp      = item.stamp;
      end else if (item.magic == MAGIC_PONG && probe_len) begin
        last_heard_next = clock_ms;
        link_up_next    = 1'b1;
        if (rtt_ok) begin
          rtt_value_next = signed'(rtt_diff[RTT_W-1:0]);
        end
      end else if (item.magic == MAGIC_STOP) begin
        pause_flag_next = 1'b1;
      end else if (item.magic == MAGIC_START) begin
        pause_flag_next = 1'b0;
      end
    end
    silence = clock_ms_next - last_heard_next;
    if (silence > {{(TIME_W-PERIOD_W){1'b0}}, cfg.timeout}) begin
      link_up_next   = 1'b0;
      rtt_value_next = RTT_NONE;
    end
  end

  always_comb begin
    result.send       = send;
    result.send_stamp = send_stamp;
    result.connected  = link_up_next;
    result.round_trip = rtt_value_next;
    result.paused     = pause_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms       <= '0;
      last_heard     <= '0;
      last_ping_sent <= '0;
      link_up        <= 1'b0;
      rtt_value      <= RTT_NONE;
      pause_flag     <= 1'b0;
    end else if (step) begin
      clock_ms       <= clock_ms_next;
      last_heard     <= last_heard_next;
      last_ping_sent <= last_ping_sent_next;
      link_up        <= link_up_next;
      rtt_value      <= rtt_value_next;
      pause_flag     <= pause_flag_next;
    end
  end

endmodule

FILE: sv/heartbeat_link_monitor.sv
// Top level of the heartbeat link monitor: input and result registers around the core.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tick or received packet
//   m_*       out        m_tvalid/m_tready  send request and link status
//   APB       in         psel/penable       ping period, timeout, round-trip limit
//
// One request per cycle is accepted while no result stalls; each result passes through
// the input register, the core's state update and the result register.
// Reset clears the valid flags and the link state; registers return to defaults.
// A stalled result holds; the input register takes one more request, then s_tready drops.
module heartbeat_link_monitor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // [31:0] magic, [37:32] length, [101:38] stamp, [103:102] zero
  input  logic [hlm_pkg::IN_DW-1:0]   s_tdata,
  // [0] kind
  input  logic                        s_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [63:0] send_stamp, [64] connected, [78:65] round_trip, [79] paused
  output logic [hlm_pkg::OUT_DW-1:0]  m_tdata,
  // [1:0] send
  output logic [1:0]                  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hlm_pkg::APB_AW-1:0]  paddr,
  input  logic [hlm_pkg::APB_DW-1:0]  pwdata,
  output logic [hlm_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import hlm_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t core_result;
  result_t out_result;
  logic    out_valid;
  logic    advance;
  logic    step;

  hlm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hlm_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (step),
    .item   (in_item),
    .result (core_result)
  );

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.kind   <= s_tuser;
      in_item.magic  <= s_tdata[31:0];
      in_item.length <= s_tdata[37:32];
      in_item.stamp  <= s_tdata[101:38];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_result.send;
  assign m_tdata  = {out_result.paused, out_result.round_trip,
                     out_result.connected, out_result.send_stamp};

endmodule

FILE: sv/hlm_checker.sv
// Port-level checks of the heartbeat link monitor and their binding to the top level.
module hlm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic [hlm_pkg::OUT_DW-1:0]  m_tdata,
  input logic [1:0]                  m_tuser
);
  import hlm_pkg::*;

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Stalled result changed.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser == SEND_NONE || m_tuser == SEND_PING || m_tuser == SEND_PONG)
    else $error("Undefined send request code.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[64] |-> m_tdata[78:65] == RTT_NONE)
    else $error("Disconnected link reports a round trip.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == SEND_NONE |-> m_tdata[63:0] == '0)
    else $error("Stamp present without a send request.");

  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

endmodule

bind heartbeat_link_monitor hlm_checker u_hlm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: tb/sv/heartbeat_link_monitor_test.sv
// Self-checking testbench for the heartbeat link monitor with APB settings and predicted status.
module heartbeat_link_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hlm_pkg::*;

  localparam int PHASES         = 7;
  localparam int RANDOM_ITEMS   = 110;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_DW-1:0]    s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_DW-1:0]   m_tdata;
  logic [1:0]          m_tuser;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [APB_AW-1:0]   paddr = '0;
  logic [APB_DW-1:0]   pwdata = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  heartbeat_link_monitor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  item_t   rx_events_q[$];
  result_t status_expected_q[$];

  // Settings the predictor works with, and the mirrored link state.
  cfg_t                    cfg;
  logic [TIME_W-1:0]       now_ms;
  logic [TIME_W-1:0]       heard_at;
  logic [TIME_W-1:0]       ping_at;
  logic                    link_up;
  logic signed [RTT_W-1:0] rtt;
  logic                    paused_now;

  // Tick count of everything queued so far, used to aim pong stamps.
  logic [TIME_W-1:0] gen_clock = '0;
  cfg_t              plan [PHASES];

  item_t   s_item;
  logic    s_taken = 1'b0;
  int      s_gap = 0;
  int      s_calm = 0;
  int      m_hold = 0;
  int      idle_cycles = 0;
  int      mismatches = 0;
  int      results_checked = 0;
  int      pings_seen = 0;
  int      pongs_seen = 0;
  int      rtt_taken = 0;
  int      link_drops = 0;
  result_t seen;
  result_t want;

  function automatic result_t advance_link(item_t it);
    result_t           r;
    logic [TIME_W-1:0] diff;
    r.send       = SEND_NONE;
    r.send_stamp = '0;
    if (!it.kind) begin
      now_ms = now_ms + 1;
      if (now_ms - ping_at >= TIME_W'(cfg.ping_period)) begin
        r.send       = SEND_PING;
        r.send_stamp = now_ms;
        ping_at      = now_ms;
      end
    end else if (it.length >= MIN_BYTES) begin
      if (it.magic == MAGIC_PING && it.length == PROBE_BYTES) begin
        heard_at     = now_ms;
        link_up      = 1'b1;
        r.send       = SEND_PONG;
        r.send_stamp = it.stamp;
      end else if (it.magic == MAGIC_PONG && it.length == PROBE_BYTES) begin
        diff     = now_ms - it.stamp;
        heard_at = now_ms;
        link_up  = 1'b1;
        if (diff < TIME_W'(cfg.rtt_limit)) begin
          rtt = diff[RTT_W-1:0];
          rtt_taken++;
        end
      end else if (it.magic == MAGIC_STOP) begin
        paused_now = 1'b1;
      end else if (it.magic == MAGIC_START) begin
        paused_now = 1'b0;
      end
    end
    if (now_ms - heard_at > TIME_W'(cfg.timeout)) begin
      if (link_up) link_drops++;
      link_up = 1'b0;
      rtt     = RTT_NONE;
    end
    r.connected  = link_up;
    r.round_trip = rtt;
    r.paused     = paused_now;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_item(logic kind, logic [MAGIC_W-1:0] magic, logic [LEN_W-1:0] len,
                          logic [TIME_W-1:0] stamp);
    item_t it;
    it.kind   = kind;
    it.magic  = magic;
    it.length = len;
    it.stamp  = stamp;
    if (!kind) gen_clock = gen_clock + 1;
    rx_events_q.push_back(it);
  endtask

  task automatic queue_directed();
    add_item(1'b0, '1, 6'd32, '1);
    add_item(1'b1, MAGIC_PING, PROBE_BYTES, '1);
    add_item(1'b1, MAGIC_PING, PROBE_BYTES, '0);
    add_item(1'b1, MAGIC_PONG, PROBE_BYTES, gen_clock);
    add_item(1'b1, MAGIC_PONG, PROBE_BYTES, gen_clock + 1);
    add_item(1'b0, '0, '0, '0);
    add_item(1'b1, MAGIC_PONG, PROBE_BYTES, '0);
    add_item(1'b1, MAGIC_PONG, 6'd11, '0);
    add_item(1'b1, MAGIC_PING, 6'd13, '0);
    add_item(1'b1, MAGIC_PING, 6'd3, '0);
    add_item(1'b1, MAGIC_PONG, MIN_BYTES, '0);
    add_item(1'b1, MAGIC_STOP, 6'd0, '0);
    add_item(1'b1, MAGIC_STOP, MIN_BYTES, '0);
    add_item(1'b1, MAGIC_STOP, 6'd32, '1);
    add_item(1'b1, MAGIC_START, 6'd3, '0);
    add_item(1'b1, MAGIC_START, 6'd32, '1);
    add_item(1'b1, '0, PROBE_BYTES, '1);
    add_item(1'b1, '1, 6'd32, '1);
    add_item(1'b0, '0, '0, '0);
  endtask

  task automatic queue_random(int count, logic [LIMIT_W-1:0] lim);
    int                r;
    logic [TIME_W-1:0] stamp;
    logic [LEN_W-1:0]  len;
    logic [MAGIC_W-1:0] magic;
    for (int i = 0; i < count; i++) begin
      r     = $urandom_range(0, 99);
      stamp = {$urandom, $urandom};
      len   = LEN_W'($urandom_range(0, 32));
      magic = $urandom;
      if (r < 45) begin
        add_item(1'b0, magic, len, stamp);
      end else if (r < 60) begin
        add_item(1'b1, MAGIC_PING, PROBE_BYTES, stamp);
      end else if (r < 75) begin
        if ($urandom_range(0, 3) == 0) stamp = gen_clock + TIME_W'($urandom_range(1, 4));
        else stamp = gen_clock - TIME_W'($urandom_range(0, int'(lim) + 2));
        add_item(1'b1, MAGIC_PONG, PROBE_BYTES, stamp);
      end else if (r < 79) begin
        add_item(1'b1, MAGIC_PONG, PROBE_BYTES, stamp);
      end else if (r < 84) begin
        add_item(1'b1, MAGIC_STOP, LEN_W'($urandom_range(4, 32)), stamp);
      end else if (r < 89) begin
        add_item(1'b1, MAGIC_START, LEN_W'($urandom_range(4, 32)), stamp);
      end else if (r < 93) begin
        if (len == PROBE_BYTES) len = len + 6'd1;
        add_item(1'b1, $urandom_range(0, 1) ? MAGIC_PING : MAGIC_PONG, len, stamp);
      end else if (r < 96) begin
        case ($urandom_range(0, 3))
          0:       magic = MAGIC_PING;
          1:       magic = MAGIC_PONG;
          2:       magic = MAGIC_STOP;
          default: magic = MAGIC_START;
        endcase
        add_item(1'b1, magic, LEN_W'($urandom_range(0, 3)), stamp);
      end else begin
        add_item(1'b1, magic, len, stamp);
      end
    end
  endtask

  task automatic reg_write(reg_index_t idx, logic [APB_DW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) begin
      $display("%0t: register %s read back expected %h got %h", $time, idx.name(), val, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_PING_PERIOD: cfg.ping_period = val[PERIOD_W-1:0];
      REG_TIMEOUT:     cfg.timeout     = val[PERIOD_W-1:0];
      default:         cfg.rtt_limit   = val[LIMIT_W-1:0];
    endcase
  endtask

  // Request driver.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      s_taken = 1'b0;
      if (s_gap > 0) begin
        s_gap--;
        s_tvalid <= 1'b0;
      end else if (rx_events_q.size() > 0) begin
        s_item = rx_events_q.pop_front();
        s_tdata  <= {2'b00, s_item.stamp, s_item.length, s_item.magic};
        s_tuser  <= s_item.kind;
        s_tvalid <= 1'b1;
        if (s_calm > 0) begin
          s_calm--;
        end else begin
          s_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) s_calm = 40;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with random back-pressure.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_hold > 0) begin
      m_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) m_hold = pick_gap();
    end
  end

  // Prediction on accepted requests, checking of accepted results, watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = advance_link(s_item);
        status_expected_q.push_back(want);
        s_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        seen.send       = send_t'(m_tuser);
        seen.send_stamp = m_tdata[63:0];
        seen.connected  = m_tdata[64];
        seen.round_trip = m_tdata[78:65];
        seen.paused     = m_tdata[79];
        if (status_expected_q.size() == 0) begin
          $display("%0t: unexpected result send=%0d stamp=%h", $time, m_tuser, seen.send_stamp);
          mismatches++;
        end else begin
          want = status_expected_q.pop_front();
          results_checked++;
          if (want.send == SEND_PING) pings_seen++;
          if (want.send == SEND_PONG) pongs_seen++;
          if (seen.send !== want.send) begin
            $display("%0t: send expected %0d got %0d", $time, want.send, seen.send);
            mismatches++;
          end
          if (seen.send_stamp !== want.send_stamp) begin
            $display("%0t: send_stamp expected %h got %h", $time, want.send_stamp,
                     seen.send_stamp);
            mismatches++;
          end
          if (seen.connected !== want.connected) begin
            $display("%0t: connected expected %b got %b", $time, want.connected,
                     seen.connected);
            mismatches++;
          end
          if (seen.round_trip !== want.round_trip) begin
            $display("%0t: round_trip expected %0d got %0d", $time, want.round_trip,
                     seen.round_trip);
            mismatches++;
          end
          if (seen.paused !== want.paused) begin
            $display("%0t: paused expected %b got %b", $time, want.paused, seen.paused);
            mismatches++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                   idle_cycles, status_expected_q.size());
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  initial begin
    plan[0] = '{ping_period: PING_PERIOD_RESET, timeout: TIMEOUT_RESET,
                rtt_limit: RTT_LIMIT_RESET};
    plan[1] = '{ping_period: 16'd1,     timeout: 16'd1,     rtt_limit: 13'd1};
    plan[2] = '{ping_period: 16'd0,     timeout: 16'd0,     rtt_limit: 13'd0};
    plan[3] = '{ping_period: 16'd65535, timeout: 16'd65535, rtt_limit: 13'd8191};
    plan[4] = '{ping_period: 16'd5,     timeout: 16'd20,    rtt_limit: 13'd40};
    plan[5] = '{ping_period: 16'd17,    timeout: 16'd60,    rtt_limit: 13'd300};
    plan[6] = '{ping_period: 16'd3,     timeout: 16'd8,     rtt_limit: 13'd8191};
    cfg        = plan[0];
    now_ms     = '0;
    heard_at   = '0;
    ping_at    = '0;
    link_up    = 1'b0;
    rtt        = RTT_NONE;
    paused_now = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        while (rx_events_q.size() > 0 || s_tvalid || status_expected_q.size() > 0)
          @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        reg_write(REG_PING_PERIOD, APB_DW'(plan[p].ping_period));
        reg_write(REG_TIMEOUT, APB_DW'(plan[p].timeout));
        reg_write(REG_RTT_LIMIT, APB_DW'(plan[p].rtt_limit));
      end
      @(posedge clk);
      if (p == 0) begin
        queue_directed();
        queue_random(40, plan[p].rtt_limit);
      end else begin
        queue_random(RANDOM_ITEMS, plan[p].rtt_limit);
      end
    end
    while (rx_events_q.size() > 0 || s_tvalid || status_expected_q.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results under %0d register settings, reaching tick %0d.",
             results_checked, PHASES, now_ms);
    $display("Saw %0d pings, %0d pongs, %0d round trips taken and %0d link drops.",
             pings_seen, pongs_seen, rtt_taken, link_drops);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
